/* hw/rtl/sqlcs_pkg.sv */
`default_nettype none
package sqlcs_pkg;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam int unsigned BUF_DEPTH = 3;

	typedef enum logic [4:0] {
		MODE_NORMAL     = 5'b00001,
		MODE_QUOTED     = 5'b00010,
		MODE_LINE       = 5'b00100,
		MODE_BLOCK      = 5'b01000,
		MODE_BLOCK_STAR = 5'b10000
	} scan_mode_t;

	typedef enum logic [1:0] {
		QK_NONE    = 2'd0,
		QK_SINGLE  = 2'd1,
		QK_DOUBLE  = 2'd2,
		QK_BRACKET = 2'd3
	} quote_kind_t;

	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_DASH  = 2'd1,
		HOLD_SLASH = 2'd2
	} hold_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
	} result_t;

	function automatic logic [7:0] closer_of(quote_kind_t kind);
		unique case (kind)
			QK_SINGLE: closer_of = CH_SQUOTE;
			QK_DOUBLE: closer_of = CH_DQUOTE;
			default:   closer_of = CH_RBRACK;
		endcase
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sqlcs_if.sv */
`default_nettype none
interface sqlcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface sqlcs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;

	modport source (output valid, output out_byte, output byte_valid, output out_last,
		input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input out_last,
		output ready);
endinterface
`default_nettype wire

/* hw/rtl/sql_comment_stripper.sv */
`default_nettype none
// SQL comment stripper. Takes one text byte per word on in_text and passes the text on
// out_text with "--" line comments (newline kept) and slash-star block comments removed;
// quoted and bracketed text passes unchanged. One byte can be accepted every cycle while
// in_text.ready is high. A byte yields zero, one or two output words (two when a held
// '-' or '/' is released alongside the next byte, or at end of text); words queue in a
// three-entry result buffer, and in_text.ready is high while at least two entries are
// free. Sustained rate is one byte per cycle while output needs stay at one word per
// byte; the output side delivers one word per cycle while out_text.ready is high. The
// word flagged end_of_text always produces a word with out_last set (a bare marker with
// byte_valid low if nothing else is kept), and all scan state returns to reset after it.
module sql_comment_stripper (
	input  wire           clk,
	input  wire           arst_n,
	sqlcs_in_if.sink      in_text,
	sqlcs_out_if.source   out_text
);
	import sqlcs_pkg::*;

	scan_mode_t  mode_q, mode_d;
	quote_kind_t kind_q, kind_d;
	hold_t       pend_q, pend_d;
	logic [7:0]  lk_q, lk_d;

	result_t     buf_q [BUF_DEPTH];
	result_t     buf_d [BUF_DEPTH];
	logic [1:0]  cnt_q, cnt_d;

	result_t     r0, r1;
	logic [1:0]  rcnt;
	logic        do_norm;
	logic        opener;
	logic [7:0]  b;
	logic        in_fire, out_fire;

	assign b        = in_text.in_byte;
	assign in_fire  = in_text.valid && in_text.ready;
	assign out_fire = out_text.valid && out_text.ready;

	assign in_text.ready       = (cnt_q <= 2'd1);
	assign out_text.valid      = (cnt_q != 2'd0);
	assign out_text.out_byte   = buf_q[0].out_byte;
	assign out_text.byte_valid = buf_q[0].byte_valid;
	assign out_text.out_last   = buf_q[0].out_last;

	assign opener = (b == CH_SQUOTE) || (b == CH_DQUOTE) || (b == CH_LBRACK);

	// Scan one byte; results land in r0/r1 in order
	always_comb begin
		mode_d  = mode_q;
		kind_d  = kind_q;
		pend_d  = pend_q;
		lk_d    = lk_q;
		r0      = '0;
		r1      = '0;
		rcnt    = 2'd0;
		do_norm = 1'b0;

		unique case (mode_q)
			MODE_QUOTED: begin
				if (b == closer_of(kind_q) && lk_q != CH_BSLASH) begin
					mode_d = MODE_NORMAL;
					kind_d = QK_NONE;
				end
				r0   = '{out_byte: b, byte_valid: 1'b1, out_last: 1'b0};
				rcnt = 2'd1;
				lk_d = b;
			end
			MODE_LINE: begin
				if (b == CH_NL) begin
					mode_d = MODE_NORMAL;
					r0     = '{out_byte: b, byte_valid: 1'b1, out_last: 1'b0};
					rcnt   = 2'd1;
					lk_d   = b;
				end
			end
			MODE_BLOCK: begin
				if (b == CH_STAR)
					mode_d = MODE_BLOCK_STAR;
			end
			MODE_BLOCK_STAR: begin
				if (b == CH_SLASH)
					mode_d = MODE_NORMAL;
				else if (b != CH_STAR)
					mode_d = MODE_BLOCK;
			end
			default: begin
				mode_d  = MODE_NORMAL;
				pend_d  = HOLD_NONE;
				do_norm = 1'b1;
				if (pend_q == HOLD_DASH) begin
					if (b == CH_DASH) begin
						mode_d  = MODE_LINE;
						do_norm = 1'b0;
					end else begin
						r0   = '{out_byte: CH_DASH, byte_valid: 1'b1, out_last: 1'b0};
						rcnt = 2'd1;
						lk_d = CH_DASH;
					end
				end else if (pend_q == HOLD_SLASH) begin
					if (b == CH_STAR) begin
						mode_d  = MODE_BLOCK;
						do_norm = 1'b0;
					end else begin
						r0   = '{out_byte: CH_SLASH, byte_valid: 1'b1, out_last: 1'b0};
						rcnt = 2'd1;
						lk_d = CH_SLASH;
					end
				end
			end
		endcase

		if (do_norm) begin
			priority if (opener && lk_d != CH_BSLASH) begin
				kind_d = (b == CH_SQUOTE) ? QK_SINGLE :
					(b == CH_DQUOTE) ? QK_DOUBLE : QK_BRACKET;
				mode_d = MODE_QUOTED;
			end else if (b == CH_DASH) begin
				pend_d = HOLD_DASH;
			end else if (b == CH_SLASH) begin
				pend_d = HOLD_SLASH;
			end else begin
			end
			if (!(b == CH_DASH || b == CH_SLASH) || (opener && lk_d != CH_BSLASH)) begin
				if (rcnt == 2'd0)
					r0 = '{out_byte: b, byte_valid: 1'b1, out_last: 1'b0};
				else
					r1 = '{out_byte: b, byte_valid: 1'b1, out_last: 1'b0};
				rcnt = rcnt + 2'd1;
				lk_d = b;
			end
		end

		if (in_text.end_of_text) begin
			// release a held opener, then flag the final word
			if (pend_d != HOLD_NONE) begin
				if (rcnt == 2'd0)
					r0 = '{out_byte: (pend_d == HOLD_DASH) ? CH_DASH : CH_SLASH,
						byte_valid: 1'b1, out_last: 1'b0};
				else
					r1 = '{out_byte: (pend_d == HOLD_DASH) ? CH_DASH : CH_SLASH,
						byte_valid: 1'b1, out_last: 1'b0};
				rcnt = rcnt + 2'd1;
			end
			if (rcnt == 2'd0) begin
				r0   = '{out_byte: 8'h00, byte_valid: 1'b0, out_last: 1'b1};
				rcnt = 2'd1;
			end else if (rcnt == 2'd1) begin
				r0.out_last = 1'b1;
			end else begin
				r1.out_last = 1'b1;
			end
			mode_d = MODE_NORMAL;
			kind_d = QK_NONE;
			pend_d = HOLD_NONE;
			lk_d   = 8'h00;
		end
	end

	// Result buffer: pop head, then append this byte's words
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++)
			buf_d[i] = buf_q[i];
		cnt_d = cnt_q;
		if (out_fire) begin
			for (int i = 0; i < BUF_DEPTH - 1; i++)
				buf_d[i] = buf_q[i + 1];
			cnt_d = cnt_q - 2'd1;
		end
		if (in_fire) begin
			if (rcnt != 2'd0)
				buf_d[cnt_d] = r0;
			if (rcnt == 2'd2)
				buf_d[cnt_d + 2'd1] = r1;
			cnt_d = cnt_d + rcnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			kind_q <= QK_NONE;
			pend_q <= HOLD_NONE;
			lk_q   <= 8'h00;
			cnt_q  <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
			if (in_fire) begin
				mode_q <= mode_d;
				kind_q <= kind_d;
				pend_q <= pend_d;
				lk_q   <= lk_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < BUF_DEPTH; i++)
			buf_q[i] <= buf_d[i];
	end

	a_pend_only_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != HOLD_NONE) |-> (mode_q == MODE_NORMAL))
		else $error("opener held outside normal text");

	a_kind_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_QUOTED) == (kind_q != QK_NONE))
		else $error("quote kind out of step with scan mode");

	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_text.valid && !out_text.byte_valid) |-> out_text.out_last)
		else $error("bare word without last flag");

	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_text.end_of_text) |=>
			(mode_q == MODE_NORMAL && pend_q == HOLD_NONE && lk_q == 8'h00))
		else $error("state not cleared after end of text");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (cnt_q <= 2'd1))
		else $error("byte accepted without buffer room");

endmodule
`default_nettype wire

/* sim/tb_sql_comment_stripper.sv */
`default_nettype none
module tb_sql_comment_stripper;
	import sqlcs_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       eot;
	} text_byte_t;

	logic clk;
	logic arst_n;

	sqlcs_in_if  in_text();
	sqlcs_out_if out_text();

	sql_comment_stripper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_text  (in_text),
		.out_text (out_text)
	);

	text_byte_t text_items[$];
	result_t    expected_words[$];

	int unsigned send_idle_pct = 37;
	int unsigned recv_idle_pct = 65;
	logic        hold_off      = 1'b0;

	int unsigned bytes_taken   = 0;
	int unsigned queries_done  = 0;
	int unsigned words_checked = 0;
	int unsigned fail_count    = 0;

	// stripper state as the testbench sees it
	scan_mode_t  mode      = MODE_NORMAL;
	quote_kind_t qkind     = QK_NONE;
	hold_t       held      = HOLD_NONE;
	logic [7:0]  last_kept = 8'h00;

	logic [7:0] specials [10] = '{CH_SQUOTE, CH_DQUOTE, CH_LBRACK, CH_RBRACK, CH_BSLASH,
		CH_DASH, CH_SLASH, CH_STAR, CH_NL, 8'h20};

	always #10 clk = ~clk;

	function automatic void append_text_item(text_byte_t item);
		text_items.insert(text_items.size(), item);
	endfunction

	function automatic void append_expected(result_t w);
		expected_words.insert(expected_words.size(), w);
	endfunction

	function automatic void push_byte(logic [7:0] b, logic eot);
		text_byte_t item;
		item.data = b;
		item.eot  = eot;
		append_text_item(item);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1);
	endfunction

	// mostly letters, now and then a byte that matters to the scanner
	function automatic logic [7:0] text_char();
		if ($urandom_range(0, 2) == 0)
			text_char = specials[$urandom_range(0, 9)];
		else
			text_char = 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic void keep_byte(logic [7:0] b);
		result_t w;
		w.out_byte   = b;
		w.byte_valid = 1'b1;
		w.out_last   = 1'b0;
		append_expected(w);
		last_kept = b;
	endfunction

	// plain text with nothing held back
	function automatic void scan_plain(logic [7:0] b);
		if ((b == CH_SQUOTE || b == CH_DQUOTE || b == CH_LBRACK) && last_kept != CH_BSLASH) begin
			if (b == CH_SQUOTE)
				qkind = QK_SINGLE;
			else if (b == CH_DQUOTE)
				qkind = QK_DOUBLE;
			else
				qkind = QK_BRACKET;
			mode = MODE_QUOTED;
			keep_byte(b);
		end else if (b == CH_DASH) begin
			held = HOLD_DASH;
		end else if (b == CH_SLASH) begin
			held = HOLD_SLASH;
		end else begin
			keep_byte(b);
		end
	endfunction

	function automatic void strip_byte(logic [7:0] b, logic eot);
		int unsigned words_before;
		logic [7:0]  closing;
		result_t     tail;
		words_before = expected_words.size();
		if (qkind == QK_SINGLE)
			closing = CH_SQUOTE;
		else if (qkind == QK_DOUBLE)
			closing = CH_DQUOTE;
		else
			closing = CH_RBRACK;
		case (mode)
			MODE_QUOTED: begin
				if (b == closing && last_kept != CH_BSLASH) begin
					mode  = MODE_NORMAL;
					qkind = QK_NONE;
				end
				keep_byte(b);
			end
			MODE_LINE: begin
				if (b == CH_NL) begin
					mode = MODE_NORMAL;
					keep_byte(b);
				end
			end
			MODE_BLOCK: begin
				if (b == CH_STAR)
					mode = MODE_BLOCK_STAR;
			end
			MODE_BLOCK_STAR: begin
				if (b == CH_SLASH)
					mode = MODE_NORMAL;
				else if (b != CH_STAR)
					mode = MODE_BLOCK;
			end
			default: begin
				mode = MODE_NORMAL;
				if (held == HOLD_DASH) begin
					held = HOLD_NONE;
					if (b == CH_DASH) begin
						mode = MODE_LINE;
					end else begin
						keep_byte(CH_DASH);
						scan_plain(b);
					end
				end else if (held == HOLD_SLASH) begin
					held = HOLD_NONE;
					if (b == CH_STAR) begin
						mode = MODE_BLOCK;
					end else begin
						keep_byte(CH_SLASH);
						scan_plain(b);
					end
				end else begin
					scan_plain(b);
				end
			end
		endcase
		if (eot) begin
			if (held == HOLD_DASH)
				keep_byte(CH_DASH);
			else if (held == HOLD_SLASH)
				keep_byte(CH_SLASH);
			if (expected_words.size() == words_before) begin
				tail.out_byte   = 8'h00;
				tail.byte_valid = 1'b0;
				tail.out_last   = 1'b1;
				append_expected(tail);
			end else begin
				tail = expected_words.pop_back();
				tail.out_last = 1'b1;
				append_expected(tail);
			end
			mode      = MODE_NORMAL;
			qkind     = QK_NONE;
			held      = HOLD_NONE;
			last_kept = 8'h00;
		end
	endfunction

	// sender: a word stays on the bus until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_text.valid       <= 1'b0;
			in_text.in_byte     <= 8'h00;
			in_text.end_of_text <= 1'b0;
		end else begin
			if (in_text.valid && in_text.ready) begin
				strip_byte(in_text.in_byte, in_text.end_of_text);
				void'(text_items.pop_front());
				bytes_taken++;
				if (in_text.end_of_text)
					queries_done++;
			end
			if (in_text.valid && !in_text.ready) begin
				// hold
			end else if (text_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_text.valid       <= 1'b1;
				in_text.in_byte     <= text_items[0].data;
				in_text.end_of_text <= text_items[0].eot;
			end else begin
				in_text.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			out_text.ready <= 1'b0;
		end else begin
			if (out_text.valid && out_text.ready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected word byte=%02h valid=%b last=%b", $realtime,
							out_text.out_byte, out_text.byte_valid, out_text.out_last);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (out_text.out_byte !== want.out_byte ||
					    out_text.byte_valid !== want.byte_valid ||
					    out_text.out_last !== want.out_last) begin
						if (fail_count < 10)
							$display("%0t: word %0d want %02h/%b/%b got %02h/%b/%b",
								$realtime, words_checked, want.out_byte, want.byte_valid,
								want.out_last, out_text.out_byte, out_text.byte_valid,
								out_text.out_last);
						fail_count++;
					end
				end
			end
			out_text.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// long receiver stall so the result buffer fills and input backs up
	initial begin
		while (bytes_taken < 1350)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (300)
			@(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int          tokens;
		logic [7:0]  open_ch;
		logic [7:0]  close_ch;
		text_byte_t  tail;

		clk                 = 1'b0;
		arst_n              = 1'b0;
		in_text.valid       = 1'b0;
		in_text.in_byte     = 8'h00;
		in_text.end_of_text = 1'b0;
		out_text.ready      = 1'b0;

		// directed queries: byte extremes, held dash at end, line comment with newline,
		// opener star not closing, star run before the close, byte after the close,
		// bracket closing on ']', escaped quote, unclosed quote and unclosed block
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_text("-");
		push_text("--c\nx");
		push_text("/*/**/-");
		push_text("[\"]");
		push_text("\\'");
		push_text("'/*");
		push_text("/*");

		while (text_items.size() < 1750) begin
			tokens = $urandom_range(1, 12);
			repeat (tokens) begin
				case ($urandom_range(0, 11))
					0: repeat ($urandom_range(1, 6))
						push_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
					1: repeat ($urandom_range(1, 4))
						push_byte(8'($urandom_range(0, 255)), 1'b0);
					2, 3, 4: begin
						case ($urandom_range(0, 2))
							0: begin open_ch = CH_SQUOTE; close_ch = CH_SQUOTE; end
							1: begin open_ch = CH_DQUOTE; close_ch = CH_DQUOTE; end
							default: begin open_ch = CH_LBRACK; close_ch = CH_RBRACK; end
						endcase
						push_byte(open_ch, 1'b0);
						repeat ($urandom_range(0, 6))
							push_byte(text_char(), 1'b0);
						if ($urandom_range(0, 7) != 0)
							push_byte(close_ch, 1'b0);
					end
					5: begin
						push_byte(CH_DASH, 1'b0);
						push_byte(CH_DASH, 1'b0);
						repeat ($urandom_range(0, 6))
							push_byte(text_char(), 1'b0);
						if ($urandom_range(0, 5) != 0)
							push_byte(CH_NL, 1'b0);
					end
					6: begin
						push_byte(CH_SLASH, 1'b0);
						push_byte(CH_STAR, 1'b0);
						repeat ($urandom_range(0, 6))
							push_byte(text_char(), 1'b0);
						if ($urandom_range(0, 5) != 0) begin
							repeat ($urandom_range(1, 3))
								push_byte(CH_STAR, 1'b0);
							push_byte(CH_SLASH, 1'b0);
						end
					end
					7: begin
						push_byte($urandom_range(0, 1) ? CH_DASH : CH_SLASH, 1'b0);
						push_byte(text_char(), 1'b0);
					end
					8: push_byte($urandom_range(0, 1) ? CH_NL : 8'h20, 1'b0);
					9: begin
						push_byte(CH_BSLASH, 1'b0);
						push_byte(specials[$urandom_range(0, 2)], 1'b0);
					end
					10: push_byte(specials[$urandom_range(0, 9)], 1'b0);
					default: push_byte(CH_STAR, 1'b0);
				endcase
			end
			tail = text_items.pop_back();
			tail.eot = 1'b1;
			append_text_item(tail);
		end

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken < 600)
			@(posedge clk);
		send_idle_pct = 65;
		recv_idle_pct = 37;
		while (bytes_taken < 1200)
			@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		while (text_items.size() != 0 || in_text.valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		$display("Stripped %0d bytes in %0d queries; %0d output words checked.",
			bytes_taken, queries_done, words_checked);
		$display("Covered quoting, escapes, line and block comments, held openers, stalls.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
